@@ hdl/sfrx_pkg.sv @@
// shared types and constants for the stuffed frame receiver
`timescale 1ns / 1ps

package sfrx_pkg;

    localparam logic [7:0]  START_BYTE   = 8'h01;
    localparam logic [7:0]  ESCAPE_BYTE  = 8'h02;
    localparam logic [7:0]  END_BYTE     = 8'h03;
    localparam logic [7:0]  ESCAPE_MASK  = 8'h10;
    localparam logic [15:0] HEADER_BYTES = 16'd5;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

    localparam logic [1:0] ST_PAYLOAD  = 2'd0;
    localparam logic [1:0] ST_GOOD     = 2'd1;
    localparam logic [1:0] ST_BAD_SUM  = 2'd2;
    localparam logic [1:0] ST_SHORT    = 2'd3;

    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_FRAME = 2'd1,
        PH_ESC   = 2'd2
    } phase_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] command_code;
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        logic        frame_end;
        logic [1:0]  frame_status;
    } result_t;

endpackage

@@ hdl/sfrx_frame_dec.sv @@
// frame state and per-byte destuffing, header capture and checksum
`timescale 1ns / 1ps

module sfrx_frame_dec
    import sfrx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  raw_byte,
    output result_t     res
);

    phase_t      phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] cmd_reg, cmd_next;
    logic [15:0] len_reg, len_next;
    logic [7:0]  check_reg, check_next;
    logic [7:0]  xor_reg, xor_next;

    logic        in_frame;
    logic        is_start;
    logic        is_end;
    logic        is_esc;
    logic        decode_now;
    logic [7:0]  dec_byte;
    logic [15:0] pay_idx;
    logic        header_done;
    logic [15:0] pay_count;

    assign in_frame    = (phase_reg == PH_FRAME) || (phase_reg == PH_ESC);
    assign is_start    = raw_byte == START_BYTE;
    assign is_end      = raw_byte == END_BYTE;
    assign is_esc      = raw_byte == ESCAPE_BYTE;
    assign dec_byte    = (phase_reg == PH_ESC) ? (raw_byte ^ ESCAPE_MASK) : raw_byte;
    assign decode_now  = in_frame && !is_start && !is_end
                         && ((phase_reg == PH_ESC) || !is_esc);
    assign pay_idx     = count_reg - HEADER_BYTES;
    assign header_done = count_reg >= HEADER_BYTES;
    assign pay_count   = !header_done ? 16'd0
                         : ((pay_idx < len_reg) ? pay_idx : len_reg);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_FRAME:
            begin
                if (is_start)
                    phase_next = PH_FRAME;
                else if (is_end)
                    phase_next = PH_HUNT;
                else if (is_esc)
                    phase_next = PH_ESC;
                else
                    phase_next = PH_FRAME;
            end
            PH_ESC:
            begin
                if (is_end)
                    phase_next = PH_HUNT;
                else
                    phase_next = PH_FRAME;
            end
            default:
            begin
                phase_next = is_start ? PH_FRAME : PH_HUNT;
            end
        endcase
    end

    // data path and result
    always_comb
    begin
        count_next = count_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        check_next = check_reg;
        xor_next   = xor_reg;
        res        = '0;

        if (is_start)
        begin
            count_next = '0;
            cmd_next   = '0;
            len_next   = '0;
            check_next = '0;
            xor_next   = '0;
        end
        if (in_frame && is_end && !is_start)
        begin
            res.valid        = 1'b1;
            res.frame_end    = 1'b1;
            res.byte_index   = pay_count;
            if (!header_done)
                res.frame_status = ST_SHORT;
            else if (xor_reg == check_reg)
                res.frame_status = ST_GOOD;
            else
                res.frame_status = ST_BAD_SUM;
        end
        if (decode_now && (count_reg != COUNT_MAX))
        begin
            count_next = count_reg + 16'd1;
            if (count_reg < 16'd2)
            begin
                cmd_next = {cmd_reg[7:0], dec_byte};
                xor_next = xor_reg ^ dec_byte;
            end
            else if (count_reg < 16'd4)
            begin
                len_next = {len_reg[7:0], dec_byte};
                xor_next = xor_reg ^ dec_byte;
            end
            else if (count_reg == 16'd4)
            begin
                check_next = dec_byte;
            end
            else if (pay_idx < len_reg)
            begin
                xor_next           = xor_reg ^ dec_byte;
                res.valid          = 1'b1;
                res.data_byte      = dec_byte;
                res.byte_index     = pay_idx;
                res.frame_status   = ST_PAYLOAD;
            end
        end
        res.command_code = cmd_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
            cmd_reg   <= '0;
            len_reg   <= '0;
            check_reg <= '0;
            xor_reg   <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            check_reg <= check_next;
            xor_reg   <= xor_next;
        end
    end

endmodule

@@ hdl/stuffed_frame_receiver_xor_check_core.sv @@
// top level of the byte-stuffed frame receiver with xor checksum
`timescale 1ns / 1ps

// Takes one raw serial byte per request and gives at most one result per byte:
// a decoded payload byte, or a status at the end byte of a frame (good,
// checksum mismatch, too short). Every byte is handled by the destuffing
// and header logic feeding one output register, so a byte can be taken
// every clock; in_stall rises only while a result sits in the output
// register and out_stall holds it there.

module stuffed_frame_receiver_xor_check_core
    import sfrx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  raw_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] command_code,
    output logic [7:0]  data_byte,
    output logic [15:0] byte_index,
    output logic        frame_end,
    output logic [1:0]  frame_status
);

    result_t res;
    logic    take;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign take     = in_valid && !in_stall;

    sfrx_frame_dec u_dec (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .raw_byte (raw_byte),
        .res      (res)
    );

    assign out_valid_next = (take && res.valid) || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && res.valid)
            out_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign command_code = out_reg.command_code;
    assign data_byte    = out_reg.data_byte;
    assign byte_index   = out_reg.byte_index;
    assign frame_end    = out_reg.frame_end;
    assign frame_status = out_reg.frame_status;

    // payload results always carry the payload status
    a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_end) |-> (frame_status == ST_PAYLOAD))
        else $error("payload result with end status");

    // end results carry a real status and no data
    a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_end) |-> (frame_status != ST_PAYLOAD && data_byte == 8'd0))
        else $error("bad end-of-frame result");

    // a short frame never reports payload bytes
    a_short_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_status == ST_SHORT) |-> (byte_index == 16'd0))
        else $error("short frame with payload count");

    // a stalled result is held until it is taken
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result lost");

endmodule
